>>> src/sbrel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrel_pkg
// Shared constants and types for the sensor bank rising edge lister.
// ----------------------------------------------------------------------------
package sbrel_pkg;

  localparam int BYTE_W      = 8;
  localparam int SENSOR_W    = 7;
  localparam int BASE_W      = SENSOR_W - 3;
  localparam int BANK_BYTES_DEF = 10;

  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [SENSOR_W-1:0] sensor_t;
  typedef logic [BASE_W-1:0]   base_t;

  // load request from the compare stage to the emitter
  typedef struct packed {
    logic  load;
    byte_t mask;
    base_t base;
  } emit_load_t;

endpackage

>>> src/sbrel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbrel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/sbrel_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrel_emit
// Holds the risen-bit mask of one byte and sends one sensor number per
// transfer, lowest bit first, flagging the last one.
// ----------------------------------------------------------------------------
module sbrel_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  sbrel_pkg::emit_load_t ld,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sbrel_pkg::sensor_t   sensor_number,
  output logic                 last_of_byte
);
  import sbrel_pkg::*;

  byte_t mask;
  byte_t mask_next;
  base_t base;
  byte_t remaining;
  logic [2:0] bit_idx;
  logic out_fire;

  always_comb begin
    bit_idx = 3'd0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (mask[i]) begin
        bit_idx = 3'(i);
      end
    end
  end

  assign remaining     = mask & (mask - 8'd1);
  assign out_valid     = |mask;
  assign last_of_byte  = (remaining == '0);
  assign sensor_number = {base, ~bit_idx};
  assign out_fire      = out_valid && !out_stall;
  assign ready         = !out_valid || (out_fire && last_of_byte);

  always_comb begin
    mask_next = mask;
    if (out_fire) begin
      mask_next = remaining;
    end
    if (ld.load) begin
      mask_next = ld.mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      base <= ld.base;
    end
  end

`ifndef ASSERT_OFF
  a_load_when_ready: assert property (@(posedge clk) disable iff (rst)
    ld.load |-> ready)
    else $error("emitter loaded while busy");
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_of_byte) |=> out_valid)
    else $error("results of a byte lost");
  a_fire_clears_bit: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !ld.load) |=> ($countones(mask) == $countones($past(mask)) - 1))
    else $error("emitter did not drop exactly one bit");
`endif

endmodule

>>> src/sensor_bank_rising_edge_lister.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_bank_rising_edge_lister
// Compares each status byte with the byte of the previous scan at the same
// bank position and lists the sensors whose bit rose from 0 to 1.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// input    in   in_valid/in_stall    status_byte
// output   out  out_valid/out_stall  sensor_number, last_of_byte
//
// A byte is read from the history RAM on transfer and compared in the cycle
// after; its first result goes out through the emitter mask register. A byte
// with risen bits holds the emitter until each is sent (none: done in compare),
// while compare takes the next byte; same-entry back-to-back reads forward.
// Reset clears the per-entry valid flags; the RAM contents need no sweep.
// Output stall backs up into in_stall once the emitter and compare stage fill.
// ----------------------------------------------------------------------------
module sensor_bank_rising_edge_lister #(
  parameter int BANK_BYTES = sbrel_pkg::BANK_BYTES_DEF,
  parameter int PW         = (BANK_BYTES > 1) ? $clog2(BANK_BYTES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbrel_pkg::byte_t   status_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output sbrel_pkg::sensor_t sensor_number,
  output logic               last_of_byte
);
  import sbrel_pkg::*;

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic          in_fire;

  logic          s1_valid;
  logic [PW-1:0] s1_pos;
  byte_t         s1_now;
  logic          s1_hold;
  byte_t         s1_prev_q;
  logic          s1_done;

  logic          fwd;
  byte_t         fwd_data;
  logic [BANK_BYTES-1:0] vld;

  byte_t      rdata;
  byte_t      prev;
  byte_t      rose;
  logic       emit_ready;
  emit_load_t ld;
  logic [31:0] base_full;

  sbrel_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_BYTES),
    .AW    (PW)
  ) u_hist (
    .clk   (clk),
    .we    (s1_done),
    .waddr (s1_pos),
    .wdata (s1_now),
    .re    (in_fire),
    .raddr (pos),
    .rdata (rdata)
  );

  always_comb begin
    if (s1_hold) begin
      prev = s1_prev_q;
    end else if (!vld[s1_pos]) begin
      prev = '0;
    end else if (fwd) begin
      prev = fwd_data;
    end else begin
      prev = rdata;
    end
  end

  assign rose      = s1_now & ~prev;
  assign s1_done   = s1_valid && ((rose == '0) || emit_ready);
  assign in_stall  = s1_valid && !s1_done;
  assign in_fire   = in_valid && !in_stall;
  assign base_full = 32'(s1_pos) * 32'd8;

  always_comb begin
    ld.load = s1_valid && (rose != '0) && emit_ready;
    ld.mask = rose;
    ld.base = base_full[SENSOR_W-1:3];
  end

  always_comb begin
    pos_next = pos;
    if (in_fire) begin
      if (32'(pos) >= BANK_BYTES - 1) begin
        pos_next = '0;
      end else begin
        pos_next = pos + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
      s1_hold  <= 1'b0;
      fwd      <= 1'b0;
      vld      <= '0;
    end else begin
      pos     <= pos_next;
      fwd     <= in_fire && s1_done && (s1_pos == pos);
      s1_hold <= s1_valid && !s1_done;
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        vld[s1_pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos <= pos;
      s1_now <= status_byte;
    end
    fwd_data  <= s1_now;
    s1_prev_q <= prev;
  end

  sbrel_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .ld            (ld),
    .ready         (emit_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sensor_number (sensor_number),
    .last_of_byte  (last_of_byte)
  );

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    32'(pos) < BANK_BYTES)
    else $error("bank position out of range");
  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    s1_hold |-> s1_valid)
    else $error("compare stage held while empty");
  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    s1_hold |-> ($stable(s1_pos) && $stable(s1_now)))
    else $error("held item changed");
  a_fwd_same_entry: assert property (@(posedge clk) disable iff (rst)
    fwd |-> (s1_valid && (s1_pos == $past(s1_pos))))
    else $error("forward on a different entry");
`endif

endmodule

>>> verif/tb_sensor_bank_rising_edge_lister.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_bank_rising_edge_lister
// Self-checking bench for the rising edge lister. A scoreboard keeps its own
// copy of the scan history and lists the sensors that should rise for every
// byte transfer. A directed table covers the first scan after reset, the
// extreme sensor numbers and bytes with no risen bit. Random bursts then
// follow, under random output stall, one long output hold and one full drain.
// ----------------------------------------------------------------------------
module tb_sensor_bank_rising_edge_lister;
  import sbrel_pkg::*;

  localparam int BANK     = BANK_BYTES_DEF;
  localparam int DIR_N    = 25;
  localparam int RAND_N   = 480;
  localparam int TOTAL    = DIR_N + RAND_N;
  localparam int HOLD_CYC = 300;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_kind_t;

  typedef struct packed {
    byte_t     status;
    row_kind_t kind;
    sensor_t   sensor;
  } dir_row_t;

  typedef struct packed {
    sensor_t sensor;
    logic    last;
  } hit_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  byte_t   status_byte = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sensor_t sensor_number;
  logic    last_of_byte;

  byte_t   history [BANK];
  int      scan_pos = 0;
  hit_t    pending_hits [$];
  hit_t    due_hit;
  int      mismatches = 0;
  int      sent = 0;
  bit      hold_req = 1'b0;

  dir_row_t dir_tab [DIR_N];

  sensor_bank_rising_edge_lister #(.BANK_BYTES(BANK)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .status_byte   (status_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sensor_number (sensor_number),
    .last_of_byte  (last_of_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (history[k]) history[k] = '0;
    // first scan from cleared history, second scan, start of a third
    dir_tab = '{
      '{8'hFF, ROW_PREDICT, 7'd0},  '{8'h00, ROW_NONE, 7'd0},
      '{8'h80, ROW_ONE, 7'd16},     '{8'h01, ROW_ONE, 7'd31},
      '{8'hAA, ROW_PREDICT, 7'd0},  '{8'h55, ROW_PREDICT, 7'd0},
      '{8'hFF, ROW_PREDICT, 7'd0},  '{8'h00, ROW_NONE, 7'd0},
      '{8'hC3, ROW_PREDICT, 7'd0},  '{8'h01, ROW_ONE, 7'd79},
      '{8'hFF, ROW_NONE, 7'd0},     '{8'hFF, ROW_PREDICT, 7'd0},
      '{8'h7F, ROW_PREDICT, 7'd0},  '{8'h00, ROW_NONE, 7'd0},
      '{8'h55, ROW_PREDICT, 7'd0},  '{8'hAA, ROW_PREDICT, 7'd0},
      '{8'h00, ROW_NONE, 7'd0},     '{8'h80, ROW_ONE, 7'd56},
      '{8'h3C, ROW_PREDICT, 7'd0},  '{8'hFF, ROW_PREDICT, 7'd0},
      '{8'h00, ROW_NONE, 7'd0},     '{8'h7F, ROW_NONE, 7'd0},
      '{8'hFF, ROW_ONE, 7'd16},     '{8'h80, ROW_ONE, 7'd24},
      '{8'hFF, ROW_PREDICT, 7'd0}
    };
  end

  // expected sensors for one byte, lowest bit first, history updated
  function automatic void rise_scan(input byte_t now, input bit listed);
    byte_t rose;
    hit_t  h;
    rose = ~history[scan_pos] & now;
    history[scan_pos] = now;
    for (int b = 0; b < BYTE_W; b++) begin
      if (rose[b] && listed) begin
        h.sensor = sensor_t'(scan_pos * 8 + 7 - b);
        h.last   = ((rose >> (b + 1)) == 0);
        pending_hits.push_back(h);
      end
    end
    scan_pos = (scan_pos + 1 >= BANK) ? 0 : scan_pos + 1;
  endfunction

  function automatic byte_t next_byte();
    byte_t prev;
    prev = history[scan_pos];
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3, 4: return byte_t'($urandom);
      5, 6:    return prev | (8'h01 << $urandom_range(0, 7));
      7:       return prev & byte_t'($urandom);
      default: return ~prev;
    endcase
  endfunction

  function automatic void flag_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  task automatic send_byte(input byte_t b, input bit listed);
    in_valid    <= 1'b1;
    status_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rise_scan(b, listed);
    sent++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid    <= 1'b0;
      status_byte <= byte_t'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic pick_gap();
    case ($urandom_range(0, 7))
      0, 1:          ;
      2, 3, 4, 5:    pause_sender($urandom_range(1, 4));
      6:             pause_sender($urandom_range(5, 12));
      default:       pause_sender($urandom_range(20, 40));
    endcase
  endtask

  // output side: stall pattern, plus one long hold on request
  initial begin
    int mode;
    int run;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(16, 96);
        repeat (run) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 4) >= 2);
            default: out_stall <= ~out_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        flag_fault($sformatf("unexpected result: sensor %0d last %0b",
                             sensor_number, last_of_byte));
      end else begin
        due_hit = pending_hits.pop_front();
        if (due_hit.sensor !== sensor_number || due_hit.last !== last_of_byte)
          flag_fault($sformatf("mismatch: expected sensor %0d last %0b, got sensor %0d last %0b",
                               due_hit.sensor, due_hit.last, sensor_number, last_of_byte));
      end
    end
  end

  initial begin
    hit_t h;
    bit   held;
    bit   drained;
    int   burst;
    int   waited;
    held    = 1'b0;
    drained = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_tab[i].status, dir_tab[i].kind == ROW_PREDICT);
      if (dir_tab[i].kind == ROW_ONE) begin
        h.sensor = dir_tab[i].sensor;
        h.last   = 1'b1;
        pending_hits.push_back(h);
      end
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 5));
    end

    while (sent < TOTAL) begin
      if (!held && sent >= DIR_N + 120) begin
        // output held while the input keeps offering bytes
        held     = 1'b1;
        hold_req = 1'b1;
        repeat (40) send_byte(next_byte(), 1'b1);
      end else if (!drained && sent >= DIR_N + 300) begin
        drained = 1'b1;
        pause_sender(1);
        while (pending_hits.size() != 0) @(posedge clk);
        pause_sender($urandom_range(1, 20));
      end else begin
        burst = $urandom_range(1, 24);
        repeat (burst) send_byte(next_byte(), 1'b1);
        pick_gap();
      end
    end

    pause_sender(1);
    waited = 0;
    while (pending_hits.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (32) @(posedge clk);
    if (pending_hits.size() != 0)
      flag_fault($sformatf("%0d expected results never arrived", pending_hits.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
src/sbrel_pkg.sv
src/sbrel_ram.sv
src/sbrel_emit.sv
src/sensor_bank_rising_edge_lister.sv
verif/tb_sensor_bank_rising_edge_lister.sv
